>>> sv/sps_pkg.sv
`default_nettype none
package sps_pkg;

	// Width of the tracked position and of the remaining step count.
	localparam int POS_BITS = 23;
	// Signed working width for the destination bounds check.
	localparam int DEST_BITS = ((POS_BITS > 24) ? POS_BITS : 24) + 2;

	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 32;

	// Floor reciprocal of 10 in 16 fractional bits; quotient is low by at most one.
	localparam logic [12:0] RECIP_10 = 13'd6553;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_STEPS_PER_REV = 3'd0,
		REG_WIRE_MODE     = 3'd1,
		REG_REVERSE_DIR   = 3'd2,
		REG_STEP_INTERVAL = 3'd3,
		REG_MAX_POSITION  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_TICK     = 2'd0,
		KIND_RELATIVE = 2'd1,
		KIND_ABSOLUTE = 2'd2,
		KIND_HOME     = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		MODE_TWO_WIRE  = 2'd0,
		MODE_FOUR_WIRE = 2'd1,
		MODE_FIVE_WIRE = 2'd2,
		MODE_UNUSED    = 2'd3
	} wire_mode_t;

	function automatic logic [4:0] two_wire_pattern(input logic [1:0] ph);
		logic [4:0] p;
		case (ph)
			2'd0: p = 5'd2;
			2'd1: p = 5'd3;
			2'd2: p = 5'd1;
			default: p = 5'd0;
		endcase
		return p;
	endfunction

	function automatic logic [4:0] four_wire_pattern(input logic [1:0] ph);
		logic [4:0] p;
		case (ph)
			2'd0: p = 5'd5;
			2'd1: p = 5'd6;
			2'd2: p = 5'd10;
			default: p = 5'd9;
		endcase
		return p;
	endfunction

	function automatic logic [4:0] five_wire_pattern(input logic [3:0] ph);
		logic [4:0] p;
		case (ph)
			4'd0: p = 5'd22;
			4'd1: p = 5'd18;
			4'd2: p = 5'd26;
			4'd3: p = 5'd10;
			4'd4: p = 5'd11;
			4'd5: p = 5'd9;
			4'd6: p = 5'd13;
			4'd7: p = 5'd5;
			4'd8: p = 5'd21;
			4'd9: p = 5'd20;
			default: p = 5'd0;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

>>> sv/stepper_phase_sequencer.sv
`default_nettype none
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-----------------------------------------------
// request   | in_valid / in_stall        | kind, move_steps, target_position,
//           |                            | end_stop_level
// result    | out_valid / out_stall      | coil_lines, busy_res, accepted, rejected,
//           |                            | position
// config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One request per cycle sustained while out_stall stays low; each request passes the input
// register, then the result register, on its way to the outputs. The step/command
// update of the motor state is a combinational path between those two registers.
// Reset (arst_n low) clears all motor state and loads the register defaults.
// out_stall holds the result register; the input register then fills and in_stall
// rises, so no request is lost. cfg_ready is always high.
module stepper_phase_sequencer
	import sps_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     in_valid,
	output      logic                     in_stall,
	input  wire logic [1:0]               kind,
	input  wire logic [23:0]              move_steps,
	input  wire logic [22:0]              target_position,
	input  wire logic [11:0]              end_stop_level,

	output      logic                     out_valid,
	input  wire logic                     out_stall,
	output      logic [4:0]               coil_lines,
	output      logic                     busy_res,
	output      logic                     accepted,
	output      logic                     rejected,
	output      logic [POS_BITS-1:0]      position,

	input  wire logic                     cfg_valid,
	output      logic                     cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	// Configuration registers
	logic [15:0]         steps_per_rev_q;
	logic [1:0]          wire_mode_q;
	logic                reverse_dir_q;
	logic [31:0]         step_interval_q;
	logic [22:0]         max_position_q;

	// Motor state
	logic [15:0]         step_index_q,   step_index_d;
	logic [3:0]          phase10_q,      phase10_d;   // step_index mod 10
	logic                dir_forward_q,  dir_forward_d;
	logic [31:0]         since_step_q,   since_step_d;
	logic [POS_BITS-1:0] pos_q,          pos_d;
	logic [POS_BITS-1:0] remaining_q,    remaining_d;
	logic                moving_q,       moving_d;
	logic                homing_q,       homing_d;
	logic [4:0]          coil_q,         coil_d;
	logic                acc_d, rej_d;

	// Input register
	logic                valid_s1;
	logic [1:0]          kind_s1;
	logic [23:0]         move_steps_s1;
	logic [22:0]         target_s1;
	logic [11:0]         stop_s1;

	// Result register
	logic                valid_s2;
	logic [4:0]          coil_s2;
	logic                busy_s2;
	logic                acc_s2;
	logic                rej_s2;
	logic [POS_BITS-1:0] pos_s2;

	logic out_free;
	logic adv;

	assign cfg_ready = 1'b1;

	// Hold the result while the consumer stalls; let stage 1 drain into a free slot.
	assign out_free = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_per_rev_q <= 16'd200;
			wire_mode_q     <= MODE_FOUR_WIRE;
			reverse_dir_q   <= 1'b0;
			step_interval_q <= 32'd1000;
			max_position_q  <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STEPS_PER_REV: steps_per_rev_q <= cfg_data[15:0];
				REG_WIRE_MODE:     wire_mode_q     <= cfg_data[1:0];
				REG_REVERSE_DIR:   reverse_dir_q   <= cfg_data[0];
				REG_STEP_INTERVAL: step_interval_q <= cfg_data;
				REG_MAX_POSITION:  max_position_q  <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------------
	// Derived limits (depend on configuration only)
	// ---------------------------------------------------------------------------
	logic [31:0]         mask32;
	logic [31:0]         maxpos32;
	logic [31:0]         lim32;
	logic [POS_BITS-1:0] lim;

	assign mask32   = 32'((64'd1 << POS_BITS) - 64'd1);
	assign maxpos32 = 32'(max_position_q);
	assign lim32    = (maxpos32 < mask32) ? maxpos32 : mask32;
	assign lim      = lim32[POS_BITS-1:0];

	// Phase of the index reached when stepping back from zero: (steps_per_rev-1) mod 10.
	logic [15:0] wrap_idx;
	logic [28:0] wrap_prod;
	logic [12:0] wrap_quot;
	logic [15:0] wrap_rem_full;
	logic [4:0]  wrap_rem;
	logic [3:0]  wrap_phase10;

	assign wrap_idx      = steps_per_rev_q - 16'd1;
	assign wrap_prod     = 29'(wrap_idx) * 29'(RECIP_10);
	assign wrap_quot     = wrap_prod[28:16];
	assign wrap_rem_full = wrap_idx - 16'(wrap_quot) * 16'd10;
	assign wrap_rem      = wrap_rem_full[4:0];
	assign wrap_phase10  = (wrap_rem >= 5'd10) ? 4'(wrap_rem - 5'd10) : wrap_rem[3:0];

	// ---------------------------------------------------------------------------
	// One step of the phase sequence
	// ---------------------------------------------------------------------------
	logic [15:0] idx_up;
	logic [15:0] step_idx_next;
	logic [3:0]  step_ph10_next;
	logic [4:0]  step_coil_next;

	assign idx_up = step_index_q + 16'd1;

	always_comb begin
		if (dir_forward_q) begin
			if (idx_up == steps_per_rev_q || idx_up == 16'd0) begin
				step_idx_next  = '0;
				step_ph10_next = '0;
			end else begin
				step_idx_next  = idx_up;
				step_ph10_next = (phase10_q == 4'd9) ? 4'd0 : phase10_q + 4'd1;
			end
		end else begin
			if (step_index_q == 16'd0) begin
				step_idx_next  = wrap_idx;
				step_ph10_next = wrap_phase10;
			end else begin
				step_idx_next  = step_index_q - 16'd1;
				step_ph10_next = (phase10_q == 4'd0) ? 4'd9 : phase10_q - 4'd1;
			end
		end
		case (wire_mode_q)
			MODE_TWO_WIRE:  step_coil_next = two_wire_pattern(step_idx_next[1:0]);
			MODE_FOUR_WIRE: step_coil_next = four_wire_pattern(step_idx_next[1:0]);
			MODE_FIVE_WIRE: step_coil_next = five_wire_pattern(step_ph10_next);
			default:        step_coil_next = coil_q;
		endcase
	end

	// ---------------------------------------------------------------------------
	// Move bounds check
	// ---------------------------------------------------------------------------
	logic [DEST_BITS-1:0] pos_ext;
	logic [DEST_BITS-1:0] dest;
	logic [DEST_BITS-1:0] delta;
	logic [DEST_BITS-1:0] delta_mag;
	logic                 dest_bad;
	logic                 delta_neg;
	logic                 delta_zero;

	assign pos_ext = DEST_BITS'(pos_q);

	always_comb begin
		if (kind_s1 == KIND_RELATIVE)
			dest = pos_ext + {{(DEST_BITS-24){move_steps_s1[23]}}, move_steps_s1};
		else
			dest = DEST_BITS'(target_s1);
	end

	assign delta      = dest - pos_ext;
	assign delta_neg  = delta[DEST_BITS-1];
	assign delta_zero = (delta == '0);
	assign delta_mag  = delta_neg ? (~delta + DEST_BITS'(1)) : delta;
	assign dest_bad   = dest[DEST_BITS-1] || (dest > DEST_BITS'(lim));

	// ---------------------------------------------------------------------------
	// State update for the request in stage 1
	// ---------------------------------------------------------------------------
	logic        busy;
	logic [31:0] since_inc;

	assign busy      = moving_q || homing_q;
	assign since_inc = (&since_step_q) ? since_step_q : since_step_q + 32'd1;

	always_comb begin
		step_index_d  = step_index_q;
		phase10_d     = phase10_q;
		dir_forward_d = dir_forward_q;
		since_step_d  = since_step_q;
		pos_d         = pos_q;
		remaining_d   = remaining_q;
		moving_d      = moving_q;
		homing_d      = homing_q;
		coil_d        = coil_q;
		acc_d         = 1'b0;
		rej_d         = 1'b0;

		if (kind_s1 == KIND_TICK) begin
			since_step_d = since_inc;
			if (homing_q && stop_s1 == 12'd0) begin
				// End-stop reached: finish homing before any step.
				homing_d = 1'b0;
				pos_d    = '0;
			end else if (busy && since_inc >= step_interval_q) begin
				since_step_d = '0;
				step_index_d = step_idx_next;
				phase10_d    = step_ph10_next;
				coil_d       = step_coil_next;
				if (homing_q) begin
					if (pos_q != '0)
						pos_d = pos_q - POS_BITS'(1);
				end else begin
					remaining_d = remaining_q - POS_BITS'(1);
					if (remaining_q == POS_BITS'(1))
						moving_d = 1'b0;
				end
			end
		end else if (busy) begin
			rej_d = 1'b1;
		end else if (kind_s1 == KIND_RELATIVE || kind_s1 == KIND_ABSOLUTE) begin
			if (dest_bad) begin
				rej_d = 1'b1;
			end else begin
				acc_d       = 1'b1;
				pos_d       = dest[POS_BITS-1:0];
				remaining_d = delta_mag[POS_BITS-1:0];
				moving_d    = !delta_zero;
				if (!delta_zero)
					dir_forward_d = delta_neg ^ !reverse_dir_q;
			end
		end else begin
			acc_d = 1'b1;
			if (stop_s1 == 12'd0) begin
				pos_d = '0;
			end else begin
				pos_d         = lim;
				dir_forward_d = reverse_dir_q;
				homing_d      = 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_index_q  <= '0;
			phase10_q     <= '0;
			dir_forward_q <= 1'b0;
			since_step_q  <= '0;
			pos_q         <= '0;
			remaining_q   <= '0;
			moving_q      <= 1'b0;
			homing_q      <= 1'b0;
			coil_q        <= '0;
		end else if (adv) begin
			step_index_q  <= step_index_d;
			phase10_q     <= phase10_d;
			dir_forward_q <= dir_forward_d;
			since_step_q  <= since_step_d;
			pos_q         <= pos_d;
			remaining_q   <= remaining_d;
			moving_q      <= moving_d;
			homing_q      <= homing_d;
			coil_q        <= coil_d;
		end
	end

	// Input register: load whenever it is empty or draining this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			kind_s1       <= kind;
			move_steps_s1 <= move_steps;
			target_s1     <= target_position;
			stop_s1       <= end_stop_level;
		end
	end

	// Result register: advance when free, hold under out_stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (out_free)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coil_s2 <= coil_d;
			busy_s2 <= moving_d || homing_d;
			acc_s2  <= acc_d;
			rej_s2  <= rej_d;
			pos_s2  <= pos_d;
		end
	end

	assign out_valid  = valid_s2;
	assign coil_lines = coil_s2;
	assign busy_res   = busy_s2;
	assign accepted   = acc_s2;
	assign rejected   = rej_s2;
	assign position   = pos_s2;

endmodule
`default_nettype wire

>>> tb/tb_stepper_phase_sequencer.sv
`timescale 1ns / 100ps

module tb_stepper_phase_sequencer;
	import sps_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 5;
	// Two register stages from request to result; give a little margin.
	localparam int DRAIN_CYCLES = 4;
	// Longest stretch without any handshake before the run is declared hung.
	localparam int STUCK_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int REQS_PER_PHASE = 200;
	localparam int N_PHASES = 10;

	// Coil sequences indexed by the step index (bit0 is the first wire).
	localparam logic [4:0] TWO_WIRE_SEQ [4] = '{5'd2, 5'd3, 5'd1, 5'd0};
	localparam logic [4:0] FOUR_WIRE_SEQ [4] = '{5'd5, 5'd6, 5'd10, 5'd9};
	localparam logic [4:0] FIVE_WIRE_SEQ [10] = '{5'd22, 5'd18, 5'd26, 5'd10, 5'd11,
		5'd9, 5'd13, 5'd5, 5'd21, 5'd20};

	// Register settings per phase. Spread them so the wrap point, the coil mode,
	// the direction sense, the pacing and the upper bound all reach their extremes.
	localparam logic [15:0] SPR_SET [N_PHASES] = '{16'd200, 16'd1, 16'd65535, 16'd5, 16'd0,
		16'd12, 16'd3, 16'd48, 16'd65535, 16'd1};
	localparam wire_mode_t MODE_SET [N_PHASES] = '{MODE_FOUR_WIRE, MODE_TWO_WIRE,
		MODE_FIVE_WIRE, MODE_UNUSED, MODE_FIVE_WIRE, MODE_TWO_WIRE, MODE_FOUR_WIRE,
		MODE_FIVE_WIRE, MODE_UNUSED, MODE_FOUR_WIRE};
	localparam logic REV_SET [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
		1'b1, 1'b0};
	localparam logic [31:0] IVL_SET [N_PHASES] = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'd0,
		32'd3, 32'd1, 32'd0, 32'd2, 32'd0};
	localparam logic [22:0] MAXPOS_SET [N_PHASES] = '{23'h7F_FFFF, 23'd100, 23'd0, 23'd5000,
		23'd30, 23'h7F_FFFF, 23'd1, 23'd200, 23'd4095, 23'd64};

	typedef struct packed {
		logic [4:0]          coil;
		logic                busy;
		logic                taken;
		logic                refused;
		logic [POS_BITS-1:0] pos;
	} motor_result_t;

	// Tracks the motor the same way the block should, and holds the results
	// still owed by the block in request order.
	class sequencer_board;
		logic [15:0]         spr;
		wire_mode_t          wmode;
		logic                rev;
		logic [31:0]         interval;
		logic [22:0]         maxpos;

		logic [15:0]         step_idx;
		logic                fwd;
		logic [31:0]         since;
		logic [POS_BITS-1:0] pos;
		logic [POS_BITS-1:0] remaining;
		logic                moving;
		logic                homing;
		logic [4:0]          coil;

		motor_result_t       results_due[$];
		int                  fail_count;
		int                  n_requests;
		int                  n_taken;
		int                  n_refused;
		int                  n_steps;

		function new();
			spr = 16'd200;
			wmode = MODE_FOUR_WIRE;
			rev = 1'b0;
			interval = 32'd1000;
			maxpos = '1;
			step_idx = '0;
			fwd = 1'b0;
			since = '0;
			pos = '0;
			remaining = '0;
			moving = 1'b0;
			homing = 1'b0;
			coil = '0;
			fail_count = 0;
			n_requests = 0;
			n_taken = 0;
			n_refused = 0;
			n_steps = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_STEPS_PER_REV: spr = data[15:0];
				REG_WIRE_MODE:     wmode = wire_mode_t'(data[1:0]);
				REG_REVERSE_DIR:   rev = data[0];
				REG_STEP_INTERVAL: interval = data;
				REG_MAX_POSITION:  maxpos = data[22:0];
				default: ;
			endcase
		endfunction

		// Advance the step index one place and look up the new coil pattern.
		function void advance_coils();
			if (fwd) begin
				step_idx = step_idx + 16'd1;
				if (step_idx == spr)
					step_idx = '0;
			end else begin
				if (step_idx == '0)
					step_idx = spr;
				step_idx = step_idx - 16'd1;
			end
			case (wmode)
				MODE_TWO_WIRE:  coil = TWO_WIRE_SEQ[step_idx[1:0]];
				MODE_FOUR_WIRE: coil = FOUR_WIRE_SEQ[step_idx[1:0]];
				MODE_FIVE_WIRE: coil = FIVE_WIRE_SEQ[step_idx % 16'd10];
				default: ;
			endcase
			n_steps++;
		endfunction

		function void predict_request(req_kind_t k, logic [23:0] mv, logic [22:0] tgt,
				logic [11:0] stop);
			motor_result_t r;
			logic          was_busy;
			longint        delta;
			longint        dest;
			longint        eff;
			was_busy = moving | homing;
			r = '0;
			if (k == KIND_TICK) begin
				if (since != '1)
					since = since + 32'd1;
				if (homing && stop == '0) begin
					homing = 1'b0;
					pos = '0;
				end else if (was_busy && since >= interval) begin
					since = '0;
					advance_coils();
					if (homing) begin
						if (pos != '0)
							pos = pos - 1'b1;
					end else begin
						remaining = remaining - 1'b1;
						if (remaining == '0)
							moving = 1'b0;
					end
				end
			end else if (was_busy) begin
				r.refused = 1'b1;
			end else if (k == KIND_HOME) begin
				r.taken = 1'b1;
				if (stop == '0) begin
					pos = '0;
				end else begin
					pos = maxpos;
					fwd = rev;
					homing = 1'b1;
				end
			end else begin
				if (k == KIND_RELATIVE)
					delta = longint'($signed(mv));
				else
					delta = longint'(tgt) - longint'(pos);
				dest = longint'(pos) + delta;
				if (dest < 0 || dest > longint'(maxpos)) begin
					r.refused = 1'b1;
				end else begin
					r.taken = 1'b1;
					pos = POS_BITS'(dest);
					remaining = POS_BITS'((delta < 0) ? -delta : delta);
					eff = rev ? -delta : delta;
					if (eff > 0)
						fwd = 1'b1;
					else if (eff < 0)
						fwd = 1'b0;
					moving = (remaining != '0);
				end
			end
			r.coil = coil;
			r.busy = moving | homing;
			r.pos = pos;
			results_due.push_back(r);
			n_requests++;
			n_taken += r.taken;
			n_refused += r.refused;
		endfunction

		function void check_result(motor_result_t got);
			motor_result_t want;
			if (results_due.size() == 0) begin
				$error("result with none outstanding: coil_lines %0d, position %0d",
					got.coil, got.pos);
				fail_count++;
				return;
			end
			want = results_due.pop_front();
			if (got.coil !== want.coil) begin
				$error("coil_lines: expected %0d, actual %0d", want.coil, got.coil);
				fail_count++;
			end
			if (got.busy !== want.busy) begin
				$error("busy_res: expected %0d, actual %0d", want.busy, got.busy);
				fail_count++;
			end
			if (got.taken !== want.taken) begin
				$error("accepted: expected %0d, actual %0d", want.taken, got.taken);
				fail_count++;
			end
			if (got.refused !== want.refused) begin
				$error("rejected: expected %0d, actual %0d", want.refused, got.refused);
				fail_count++;
			end
			if (got.pos !== want.pos) begin
				$error("position: expected %0d, actual %0d", want.pos, got.pos);
				fail_count++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;

	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                kind = KIND_TICK;
	logic [23:0]               move_steps = '0;
	logic [22:0]               target_position = '0;
	logic [11:0]               end_stop_level = '0;

	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [4:0]                coil_lines;
	logic                      busy_res;
	logic                      accepted;
	logic                      rejected;
	logic [POS_BITS-1:0]       position;

	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	sequencer_board board = new();

	// Idle pattern knobs, set by the stimulus per phase.
	int idle_pct = 0;
	int stall_pct = 0;
	// Hold-off handshake: the stimulus bumps the ask count, the receiver counts the cycles.
	int hold_off_asks = 0;
	int hold_off_seen = 0;
	int hold_off_left = 0;
	int stuck_cycles = 0;

	stepper_phase_sequencer i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.move_steps      (move_steps),
		.target_position (target_position),
		.end_stop_level  (end_stop_level),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.coil_lines      (coil_lines),
		.busy_res        (busy_res),
		.accepted        (accepted),
		.rejected        (rejected),
		.position        (position),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Receiver: stall at random, or hold off for a long stretch when asked so
	// that the block fills up and pushes back on the request side.
	always @(negedge clk) begin
		if (hold_off_asks != hold_off_seen) begin
			hold_off_seen <= hold_off_asks;
			hold_off_left <= HOLD_OFF_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Sample every handshake at the rising edge: register writes first, then the
	// request (feeds the tracker), then the result (checked against the oldest due).
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				board.predict_request(req_kind_t'(kind), move_steps, target_position,
					end_stop_level);
			if (out_valid && !out_stall)
				board.check_result({coil_lines, busy_res, accepted, rejected, position});
			if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no handshake for %0d cycles, %0d results outstanding",
				STUCK_LIMIT, board.results_due.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// Offer one request, after a random gap, and hold it until the block takes it.
	task automatic send_request(input req_kind_t k, input logic [23:0] mv,
			input logic [22:0] tgt, input logic [11:0] stop);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		move_steps <= mv;
		target_position <= tgt;
		end_stop_level <= stop;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Drop valid and wait until every result owed has arrived, then DRAIN_CYCLES more.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.results_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Random requests. Mostly ticks to pace the steps; commands are mostly short,
	// well-formed moves around the current position and the two bounds, so that
	// moves finish and homing runs. Full-range values go out only where they cannot
	// start a move that would keep the motor busy for millions of ticks.
	task automatic run_random_batch(input int count);
		req_kind_t   k;
		logic [23:0] mv;
		logic [22:0] tgt;
		logic [11:0] stop;
		logic        wide_ok;
		int          roll;
		int          off;
		int          tv;
		repeat (count) begin
			mv = 24'($urandom);
			tgt = 23'($urandom);
			stop = ($urandom_range(0, 99) < 15) ? 12'd0 : 12'($urandom_range(1, 4095));
			wide_ok = board.moving || board.homing || (board.maxpos < 23'd4096);
			off = int'($urandom_range(0, 2)) - 1;
			roll = $urandom_range(0, 99);
			if (roll < 58) begin
				k = KIND_TICK;
			end else if (roll < 90) begin
				k = (roll < 74) ? KIND_RELATIVE : KIND_ABSOLUTE;
				if (!wide_ok || $urandom_range(0, 99) < 80) begin
					case ($urandom_range(0, 3))
						0: tv = off;
						1: tv = int'(board.maxpos) + off;
						default: tv = int'(board.pos) + int'($urandom_range(0, 40)) - 20;
					endcase
					// Keep any accepted move short.
					if (tv - int'(board.pos) > 64 || tv - int'(board.pos) < -64)
						tv = int'(board.pos) + off;
					if (k == KIND_RELATIVE)
						mv = 24'(tv - int'(board.pos));
					else
						tgt = 23'((tv < 0) ? 0 : tv);
				end
			end else begin
				k = KIND_HOME;
			end
			send_request(k, mv, tgt, stop);
		end
	endtask

	initial begin
		logic [CFG_IDX_BITS-1:0] spare_idx;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, reset register values first.
		send_request(KIND_TICK, '0, '0, 12'hFFF);          // idle tick
		send_request(KIND_RELATIVE, '0, '0, 12'd1);        // zero-length move
		send_request(KIND_RELATIVE, 24'hFF_FFFF, '0, 12'd1); // below zero
		send_request(KIND_RELATIVE, 24'h80_0000, '0, 12'd1); // most negative step count
		send_request(KIND_HOME, '0, '0, 12'd0);            // already at the end stop
		send_request(KIND_RELATIVE, 24'd3, '0, 12'd1);     // start a move
		send_request(KIND_ABSOLUTE, '0, 23'h7F_FFFF, 12'd1); // refused while busy
		send_request(KIND_HOME, '0, '0, 12'hFFF);          // refused while busy
		send_request(KIND_TICK, '0, '0, 12'd1);            // too early to step
		drain_results();
		write_reg(REG_STEP_INTERVAL, 32'd0);
		repeat (3) send_request(KIND_TICK, '0, '0, 12'd1);
		send_request(KIND_ABSOLUTE, '0, 23'd0, 12'd1);     // back to zero
		repeat (3) send_request(KIND_TICK, '0, '0, 12'd1);
		send_request(KIND_HOME, '0, '0, 12'd5);            // homing from the bound
		send_request(KIND_TICK, '0, '0, 12'd3);            // one homing step
		send_request(KIND_TICK, '0, '0, 12'd0);            // end stop reached
		drain_results();
		write_reg(REG_MAX_POSITION, 32'd10);
		write_reg(REG_REVERSE_DIR, 32'd1);
		send_request(KIND_ABSOLUTE, '0, 23'd11, 12'd1);    // just above the bound
		send_request(KIND_RELATIVE, 24'h7F_FFFF, '0, 12'd1); // largest step count
		send_request(KIND_ABSOLUTE, '0, 23'd4, 12'd1);     // reversed sense, index steps down
		repeat (4) send_request(KIND_TICK, '0, '0, 12'd1);

		// Random phases, each under its own register setting and idle pattern.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain_results();
			write_reg(REG_STEPS_PER_REV, {16'($urandom), SPR_SET[ph]});
			write_reg(REG_WIRE_MODE, {30'($urandom), MODE_SET[ph]});
			write_reg(REG_REVERSE_DIR, {31'($urandom), REV_SET[ph]});
			write_reg(REG_STEP_INTERVAL, IVL_SET[ph]);
			write_reg(REG_MAX_POSITION, {9'($urandom), MAXPOS_SET[ph]});
			// An index past the register list must leave everything alone.
			spare_idx = REG_MAX_POSITION + CFG_IDX_BITS'($urandom_range(1, 3));
			write_reg(spare_idx, $urandom);
			case (ph % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 50;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 50;
				end
				default: begin
					idle_pct = 7;
					stall_pct = 7;
				end
			endcase
			run_random_batch(REQS_PER_PHASE / 2);
			// Hold the receiver off while requests keep coming, then let the sender
			// pause until everything owed has come back.
			if (ph == 1)
				hold_off_asks = hold_off_asks + 1;
			if (ph == 2)
				drain_results();
			run_random_batch(REQS_PER_PHASE - REQS_PER_PHASE / 2);
		end

		idle_pct = 0;
		stall_pct = 0;
		drain_results();

		$display("Covered %0d requests under %0d register settings: %0d commands taken, %0d refused,",
			board.n_requests, N_PHASES + 1, board.n_taken, board.n_refused);
		$display("%0d coil steps across all wire modes, both senses, homing and bound edges.",
			board.n_steps);
		if (board.fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
